>>> rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants for the point-segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    // fraction bits of the projection parameter t (1.0 = 2^T_FRAC)
    localparam int T_FRAC = 16;

endpackage

>>> rtl/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider: t = dot / len2 as Q1.T_FRAC, one quotient bit
// per stage, with zero and saturation handling in front.
// ----------------------------------------------------------------------------
module psd_div #(
    parameter int DW = 36,
    parameter int PW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_dot,
    input  logic          i_dot_pos,
    input  logic [DW-1:0] i_len2,
    input  logic [PW-1:0] i_pass,
    output logic          o_valid,
    output logic [psd_pkg::T_FRAC:0] o_t,
    output logic [PW-1:0] o_pass
);
    import psd_pkg::*;

    localparam int NS = T_FRAC + 1;

    logic [NS-1:0]          r_v;
    logic [DW:0]            r_rem  [NS];
    logic [DW-1:0]          r_den  [NS];
    logic [T_FRAC:0]        r_q    [NS];
    logic                   r_run  [NS];
    logic [PW-1:0]          r_pass [NS];

    // stage 0: classify; later stages: one restoring step each
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_len2;
            r_pass[0] <= i_pass;
            r_rem[0]  <= {1'b0, i_dot};
            if (!i_dot_pos) begin
                r_q[0]   <= '0;
                r_run[0] <= 1'b0;
            end else if (i_dot >= i_len2) begin
                r_q[0]   <= (T_FRAC+1)'(1) << T_FRAC;
                r_run[0] <= 1'b0;
            end else begin
                r_q[0]   <= '0;
                r_run[0] <= 1'b1;
            end
            for (int s = 1; s < NS; s++) begin
                logic [DW:0] sh;
                sh = {r_rem[s-1][DW-1:0], 1'b0};
                r_den[s]  <= r_den[s-1];
                r_pass[s] <= r_pass[s-1];
                r_run[s]  <= r_run[s-1];
                if (r_run[s-1] && sh >= {1'b0, r_den[s-1]}) begin
                    r_rem[s] <= sh - {1'b0, r_den[s-1]};
                    r_q[s]   <= {r_q[s-1][T_FRAC-1:0], 1'b1};
                end else begin
                    r_rem[s] <= sh;
                    r_q[s]   <= r_run[s-1] ? {r_q[s-1][T_FRAC-1:0], 1'b0} : r_q[s-1];
                end
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_t     = r_q[NS-1];
    assign o_pass  = r_pass[NS-1];

    // a saturated or zero quotient stays fixed through the divider
    a_sat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !r_run[0] && r_v[0]) |=> (r_q[1] == $past(r_q[0])))
        else $error("psd_div: fixed quotient changed");
    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_t[T_FRAC] || o_t[T_FRAC-1:0] == '0))
        else $error("psd_div: t above one");
    a_v_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_v))
        else $error("psd_div: valid moved during stall");
endmodule

>>> rtl/psd_sqrt.sv
// ----------------------------------------------------------------------------
// psd_sqrt
// Pipelined floor integer square root, one result bit per stage
// (restoring digit recurrence on the remainder).
// ----------------------------------------------------------------------------
module psd_sqrt #(
    parameter int RW = 17
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_sq,
    output logic            o_valid,
    output logic [RW-1:0]   o_root
);
    import psd_pkg::*;

    logic [RW-1:0]   r_v;
    logic [2*RW-1:0] r_n    [RW];
    logic [RW-1:0]   r_root [RW];
    logic [RW+1:0]   r_rem  [RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RW-2:0], i_valid};
        end
    end

    // each stage brings down two radicand bits and decides one root bit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < RW; s++) begin
                logic [RW+1:0] cur;
                logic [RW+1:0] trial;
                logic [RW-1:0] rt;
                logic [2*RW-1:0] nn;
                if (s == 0) begin
                    cur = {{RW{1'b0}}, i_sq[2*RW-1 -: 2]};
                    rt  = '0;
                    nn  = {i_sq[2*RW-3:0], 2'b00};
                end else begin
                    cur = {r_rem[s-1][RW-1:0], r_n[s-1][2*RW-1 -: 2]};
                    rt  = r_root[s-1];
                    nn  = {r_n[s-1][2*RW-3:0], 2'b00};
                end
                trial = {rt, 2'b01};
                r_n[s] <= nn;
                if (cur >= trial) begin
                    r_rem[s]  <= cur - trial;
                    r_root[s] <= {rt[RW-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= cur;
                    r_root[s] <= {rt[RW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];

    a_v_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_v))
        else $error("psd_sqrt: valid moved during stall");
    a_root_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_en && o_valid) |=> $stable(o_root))
        else $error("psd_sqrt: root changed during stall");
    a_first_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_valid && i_sq == '0) |=> (r_root[0] == '0))
        else $error("psd_sqrt: nonzero root of zero");
endmodule

>>> rtl/point_segment_distance_2d.sv
// Stages: 3 + divider stages + 4 + (COORD_WIDTH+3) root stages + 1 output
// register.
// Throughput: one word per cycle; every stage advances together, so a stalled
// output holds the whole pipeline, which refills at one word per cycle.
// Reset: synchronous active-low i_rst_n clears every valid bit; data is not reset.
// ----------------------------------------------------------------------------
// point_segment_distance_2d
// Distance from a point to a segment: difference and product stages, a pipelined
// divider for t, offset, error, square and sum stages, a pipelined square root.
// ----------------------------------------------------------------------------
module point_segment_distance_2d #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_WIDTH-1:0] i_point_x,
    input  logic [COORD_WIDTH-1:0] i_point_y,
    input  logic [COORD_WIDTH-1:0] i_start_x,
    input  logic [COORD_WIDTH-1:0] i_start_y,
    input  logic [COORD_WIDTH-1:0] i_end_x,
    input  logic [COORD_WIDTH-1:0] i_end_y,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COORD_WIDTH:0]   o_distance
);
    import psd_pkg::*;

    localparam int W1 = COORD_WIDTH + 1;     // differences
    localparam int PW = 2 * W1;              // one product
    localparam int DW = PW + 1;              // sum of two products
    localparam int TW = T_FRAC + 1;
    localparam int MW = TW + W1;             // t * |d|
    localparam int EW = W1 + 2;              // error component
    localparam int SQ = 2 * EW;              // squared distance fits 2*RW
    localparam int RW = EW;

    // whole pipeline advances when the output slot is free or taken
    logic en;
    assign en = !o_valid || i_ready;
    assign o_ready = en;

    // stage 1: differences
    logic r1_v;
    logic signed [W1-1:0] r1_dx, r1_dy, r1_ux, r1_uy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx <= W1'($signed(i_end_x))   - W1'($signed(i_start_x));
            r1_dy <= W1'($signed(i_end_y))   - W1'($signed(i_start_y));
            r1_ux <= W1'($signed(i_point_x)) - W1'($signed(i_start_x));
            r1_uy <= W1'($signed(i_point_y)) - W1'($signed(i_start_y));
        end
    end

    // stage 2: four products
    logic r2_v;
    logic signed [PW-1:0] r2_pdx, r2_pdy, r2_pxx, r2_pyy;
    logic signed [W1-1:0] r2_dx, r2_dy, r2_ux, r2_uy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_pdx <= PW'(r1_ux) * PW'(r1_dx);
            r2_pdy <= PW'(r1_uy) * PW'(r1_dy);
            r2_pxx <= PW'(r1_dx) * PW'(r1_dx);
            r2_pyy <= PW'(r1_dy) * PW'(r1_dy);
            r2_dx <= r1_dx; r2_dy <= r1_dy; r2_ux <= r1_ux; r2_uy <= r1_uy;
        end
    end

    // stage 3: dot product and squared length
    logic r3_v;
    logic signed [DW-1:0] r3_dot;
    logic [DW-1:0] r3_len2;
    logic signed [W1-1:0] r3_dx, r3_dy, r3_ux, r3_uy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dot  <= DW'(r2_pdx) + DW'(r2_pdy);
            r3_len2 <= DW'($unsigned(r2_pxx)) + DW'($unsigned(r2_pyy));
            r3_dx <= r2_dx; r3_dy <= r2_dy; r3_ux <= r2_ux; r3_uy <= r2_uy;
        end
    end

    // divider, carrying the four differences alongside
    localparam int CW = 4 * W1;
    logic            dv_v;
    logic [TW-1:0]   dv_t;
    logic [CW-1:0]   dv_pass;
    psd_div #(.DW(DW), .PW(CW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r3_v),
        .i_dot(DW'($unsigned(r3_dot))),
        .i_dot_pos(!r3_dot[DW-1] && (r3_dot != '0)),
        .i_len2(r3_len2),
        .i_pass({r3_dx, r3_dy, r3_ux, r3_uy}),
        .o_valid(dv_v), .o_t(dv_t), .o_pass(dv_pass)
    );

    logic signed [W1-1:0] dv_dx, dv_dy, dv_ux, dv_uy;
    assign {dv_dx, dv_dy, dv_ux, dv_uy} = dv_pass;

    // stage 4: t * |d| products
    logic r4_v;
    logic [MW-1:0] r4_mx, r4_my;
    logic r4_nx, r4_ny;
    logic signed [W1-1:0] r4_ux, r4_uy;
    logic [W1-1:0] mag_dx, mag_dy;
    assign mag_dx = dv_dx[W1-1] ? W1'(-dv_dx) : W1'(dv_dx);
    assign mag_dy = dv_dy[W1-1] ? W1'(-dv_dy) : W1'(dv_dy);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= dv_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_mx <= MW'(dv_t) * MW'(mag_dx);
            r4_my <= MW'(dv_t) * MW'(mag_dy);
            r4_nx <= dv_dx[W1-1];
            r4_ny <= dv_dy[W1-1];
            r4_ux <= dv_ux; r4_uy <= dv_uy;
        end
    end

    // stage 5: round offsets (ties toward +inf) and form error vector
    localparam logic [MW-1:0] HALF = MW'(1) << (T_FRAC - 1);
    logic [MW-1:0] rx_s, ry_s;
    logic signed [EW-1:0] offx, offy;
    always_comb begin
        rx_s = (r4_mx + HALF - MW'(r4_nx)) >> T_FRAC;
        ry_s = (r4_my + HALF - MW'(r4_ny)) >> T_FRAC;
        offx = r4_nx ? -$signed(EW'(rx_s)) : $signed(EW'(rx_s));
        offy = r4_ny ? -$signed(EW'(ry_s)) : $signed(EW'(ry_s));
    end
    logic r5_v;
    logic signed [EW-1:0] r5_ex, r5_ey;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= r4_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_ex <= EW'(r4_ux) - offx;
            r5_ey <= EW'(r4_uy) - offy;
        end
    end

    // stage 6: squares; stage 7: sum
    logic r6_v, r7_v;
    logic [SQ-1:0] r6_sx, r6_sy, r7_d2;
    logic [EW-1:0] mex, mey;
    assign mex = r5_ex[EW-1] ? EW'(-r5_ex) : EW'(r5_ex);
    assign mey = r5_ey[EW-1] ? EW'(-r5_ey) : EW'(r5_ey);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_sx <= SQ'(mex) * SQ'(mex);
            r6_sy <= SQ'(mey) * SQ'(mey);
            r7_d2 <= r6_sx + r6_sy;
        end
    end

    logic          sq_v;
    logic [RW-1:0] sq_root;
    psd_sqrt #(.RW(RW)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r7_v),
        .i_sq(r7_d2), .o_valid(sq_v), .o_root(sq_root)
    );

    // output register
    logic r_ov;
    logic [COORD_WIDTH:0] r_dist;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en) r_ov <= sq_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) r_dist <= sq_root[COORD_WIDTH:0];
    end
    assign o_valid    = r_ov;
    assign o_distance = r_dist;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_distance)))
        else $error("output word changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipeline stalled with empty output");
    a_root_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_v |-> (sq_root[RW-1:COORD_WIDTH+1] == '0))
        else $error("distance exceeds output width");
endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for point_segment_distance_2d: a directed table of
// segments and points, then random queries, each result compared in order
// with a typed value or a behavioral model of the distance. Both handshake
// sides idle at random; the output side also holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = psd_pkg::COORD_WIDTH_DEF;
    localparam int TF = psd_pkg::T_FRAC;
    localparam int N_RANDOM = 730;

    typedef struct {
        logic [CW-1:0] px, py, ax, ay, bx, by;
        logic [CW:0]   gold;
        bit            known;  // expected value typed in the table
    } query_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [CW-1:0] px = '0, py = '0, ax = '0, ay = '0, bx = '0, by = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [CW:0]   out_dist;

    logic [CW:0] dist_queue[$];
    int          errors = 0;
    bit          hold_off = 1'b0;
    bit          calm = 1'b0;

    point_segment_distance_2d dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_point_x(px), .i_point_y(py), .i_start_x(ax), .i_start_y(ay),
        .i_end_x(bx), .i_end_y(by),
        .o_valid(out_valid), .i_ready(out_ready), .o_distance(out_dist)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // rounds t*d / 2^TF to nearest, ties upward
    function automatic longint round_offset(longint t, longint d);
        longint m;
        m = t * (d < 0 ? -d : d);
        if (d < 0) return -((m + (64'sd1 <<< (TF-1)) - 1) >>> TF);
        return (m + (64'sd1 <<< (TF-1))) >>> TF;
    endfunction

    function automatic logic [CW:0] segment_distance(query_t q);
        longint dx, dy, ux, uy, len2, dotp, t, ex, ey, d2, r, c;
        dx = longint'($signed(q.bx)) - longint'($signed(q.ax));
        dy = longint'($signed(q.by)) - longint'($signed(q.ay));
        ux = longint'($signed(q.px)) - longint'($signed(q.ax));
        uy = longint'($signed(q.py)) - longint'($signed(q.ay));
        len2 = dx*dx + dy*dy;
        dotp = ux*dx + uy*dy;
        t = 0;
        if (dotp > 0) begin
            if (dotp >= len2) t = 64'sd1 <<< TF;
            else t = (dotp <<< TF) / len2;  // fits: dotp < 2^34
        end
        ex = ux - round_offset(t, dx);
        ey = uy - round_offset(t, dy);
        d2 = ex*ex + ey*ey;
        r = 0;
        for (int b = 40; b >= 0; b--) begin
            c = r | (64'sd1 <<< b);
            if (c <= 64'sd3037000499 && c*c <= d2) r = c;
        end
        return r[CW:0];
    endfunction

    // sender: one word per accepted handshake; valid drops only while idling
    task automatic send(query_t q);
        while (!calm && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        px <= q.px; py <= q.py; ax <= q.ax; ay <= q.ay; bx <= q.bx; by <= q.by;
        in_valid <= 1'b1;
        dist_queue = {dist_queue, (q.known ? q.gold : segment_distance(q))};
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic query_t row(int p0, int p1, int a0, int a1, int b0, int b1,
                                   int d = 0, bit k = 0);
        query_t q;
        q.px = CW'(p0); q.py = CW'(p1); q.ax = CW'(a0); q.ay = CW'(a1);
        q.bx = CW'(b0); q.by = CW'(b1);
        q.gold = (CW+1)'(d); q.known = k;
        return q;
    endfunction

    function automatic logic [CW-1:0] rnd_coord();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            1: return CW'($urandom_range(63) - 32);
            2: return CW'($urandom_range(4095) - 2048);
            default: return CW'($urandom);
        endcase
    endfunction

    // receiver: random stalls plus one long hold-off
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_ready <= 1'b0;
                n = 0;
                while (n < 200) begin
                    @(posedge clk);
                    n++;
                end
                hold_off = 1'b0;
            end
            out_ready <= calm || $urandom_range(99) >= 35;
        end
    end

    // output check against oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (dist_queue.size() == 0) begin
                $error("unexpected word: distance=%0d", out_dist);
                errors++;
            end else begin
                logic [CW:0] want;
                want = dist_queue.pop_front();
                if (out_dist !== want) begin
                    $error("distance mismatch: expected %0d actual %0d", want, out_dist);
                    errors++;
                end
            end
        end
    end

    initial begin
        query_t dir[$];
        query_t q;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // degenerate segment, at origin and at corners
        dir = {dir, row(0, 0, 0, 0, 0, 0, 0, 1)};
        dir = {dir, row(48, 64, 0, 0, 0, 0, 80, 1)};
        dir = {dir, row(-32768, -32768, -32768, -32768, -32768, -32768, 0, 1)};
        // farthest corners: sqrt(2)*65535
        dir = {dir, row(32767, 32767, -32768, -32768, -32768, -32768, 92680, 1)};
        dir = {dir, row(-32768, 32767, 32767, -32768, 32767, -32768)};
        // behind start, beyond end, interior
        dir = {dir, row(-160, 0, 0, 0, 160, 0, 160, 1)};
        dir = {dir, row(320, 0, 0, 0, 160, 0, 160, 1)};
        dir = {dir, row(80, 48, 0, 0, 160, 0, 48, 1)};
        dir = {dir, row(0, 48, 0, 0, 160, 0, 48, 1)};
        dir = {dir, row(160, 48, 0, 0, 160, 0, 48, 1)};
        dir = {dir, row(5, 7, 0, 0, -3, 11)};
        dir = {dir, row(1, -1, 3, 3, -7, -2)};
        dir = {dir, row(32767, -32768, -32768, 32767, 32767, 32767)};
        dir = {dir, row(0, 0, -32768, -32768, 32767, 32767)};
        dir = {dir, row(-32768, 32767, -32768, -32768, 32767, 32767)};
        dir = {dir, row(12345, -4321, -32768, 100, 32767, -100)};
        dir = {dir, row(-1, -1, 1, 1, 2, 3)};
        dir = {dir, row(7, 0, 0, 0, 3, 0, 4, 1)};
        foreach (dir[i]) send(dir[i]);

        for (int i = 0; i < N_RANDOM; i++) begin
            q.known = 0;
            q.gold = '0;
            q.px = rnd_coord(); q.py = rnd_coord();
            q.ax = rnd_coord(); q.ay = rnd_coord();
            if ($urandom_range(15) == 0) begin
                q.bx = q.ax; q.by = q.ay;
            end else begin
                q.bx = rnd_coord(); q.by = rnd_coord();
            end
            if (i == 100) hold_off = 1'b1;
            calm = (i >= 300 && i < 420);
            if (i == 500) begin
                // sender pause until drained
                in_valid <= 1'b0;
                while (dist_queue.size() != 0) @(posedge clk);
            end
            send(q);
        end
        in_valid <= 1'b0;
        calm = 1'b0;
        while (dist_queue.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("tb: FAIL");
        $finish;
    end
endmodule
